>>> sv/pkc_pkg.sv
// Shared constants, types and arithmetic helpers for the pixel keystream cipher.
`default_nettype none

package pkc_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int KEY_BITS   = 31;
   localparam int LEVEL_BITS = 8;
   localparam int MOD_BITS   = LEVEL_BITS + 1;
   localparam int DIV_BITS   = KEY_BITS;
   localparam int MULT_BITS  = 15;
   localparam int PROD_BITS  = KEY_BITS + MULT_BITS;

   localparam logic [MULT_BITS-1:0] LEHMER_MULT = 15'd16807;
   localparam logic [KEY_BITS-1:0]  LEHMER_MOD  = 31'h7FFF_FFFF;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = KEY_BITS;

   localparam logic [KEY_BITS-1:0]   SEED_KEY_RESET  = 31'd1;
   localparam logic [LEVEL_BITS-1:0] MAX_LEVEL_RESET = 8'd255;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SEED_KEY  = 2'd0,
      REG_MAX_LEVEL = 2'd1,
      REG_DIRECTION = 2'd2
   } csr_index_type;

   // Payload moving down the divider chain: two remainders, two dividends.
   typedef struct packed {
      logic [LEVEL_BITS-1:0] rem_a;
      logic [LEVEL_BITS-1:0] rem_b;
      logic [DIV_BITS-1:0]   div_a;
      logic [PIXEL_BITS-1:0] div_b;
   } cell_data_type;

   // r * 16807 mod (2^31 - 1) using the Mersenne fold.
   function automatic logic [KEY_BITS-1:0] lehmer_next(input logic [KEY_BITS-1:0] r);
      logic [PROD_BITS-1:0] prod;
      logic [KEY_BITS:0]    fold;
      prod = PROD_BITS'(r) * PROD_BITS'(LEHMER_MULT);
      fold = (KEY_BITS+1)'(prod[KEY_BITS-1:0]) + (KEY_BITS+1)'(prod[PROD_BITS-1:KEY_BITS]);
      if (fold >= {1'b0, LEHMER_MOD}) begin
         fold = fold - {1'b0, LEHMER_MOD};
      end
      return fold[KEY_BITS-1:0];
   endfunction

   // One restoring step: shift in a dividend bit, subtract modulus if it fits.
   function automatic logic [LEVEL_BITS-1:0] mod_step(input logic [LEVEL_BITS-1:0] rem,
                                                      input logic                  din,
                                                      input logic [MOD_BITS-1:0]   modulus);
      logic [MOD_BITS-1:0] t;
      t = {rem, din};
      if (t >= modulus) begin
         t = t - modulus;
      end
      return t[LEVEL_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/pkc_req_if.sv
// Input pixel channel: valid/ready handshake with pixel and first-pixel flag.
`default_nettype none

interface pkc_req_if;
   logic                           valid;
   logic                           ready;
   logic [pkc_pkg::PIXEL_BITS-1:0] pixel_in;
   logic                           first_pixel;

   modport source (output valid, output pixel_in, output first_pixel, input ready);
   modport sink   (input valid, input pixel_in, input first_pixel, output ready);
endinterface

`default_nettype wire

>>> sv/pkc_rsp_if.sv
// Result pixel channel: valid/ready handshake with the ciphered pixel.
`default_nettype none

interface pkc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pkc_pkg::PIXEL_BITS-1:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

>>> sv/pixel_keystream_cipher_unit.sv
// Top level of the pixel keystream cipher: CSRs, generator, divider chain, output.
//
//   channel  | dir | handshake           | beat contents
//   ---------+-----+---------------------+-------------------------------------
//   req_chan | in  | valid/ready         | pixel_in, first_pixel
//   rsp_chan | out | valid/ready         | pixel_out
//   csr_*    | in  | csr_wr_en, no wait  | csr_index, csr_wdata
//
// Flow: one pixel beat per cycle sustained while rsp_chan is ready; rsp valid follows
//   the req accept through 33 registers: 1 generator stage, 31 divider cells, 1 output reg.
// The 31-cell remainder chain sets the latency; the generator step sets the rate.
// Reset: synchronous, clears CSRs to defaults and all stage valids; no sweep.
// Stalls: each stage moves when its neighbor below is empty or moving, so
//   bubbles collapse and req keeps flowing until the chain fills up.
`default_nettype none

module pixel_keystream_cipher_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   pkc_req_if.sink                                   req_chan,
   pkc_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pkc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [pkc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CELLS = pkc_pkg::DIV_BITS;

   // Configuration registers
   logic [pkc_pkg::KEY_BITS-1:0]   seed_key_ff;
   logic [pkc_pkg::LEVEL_BITS-1:0] max_level_ff;
   logic                           direction_ff;
   logic [pkc_pkg::MOD_BITS-1:0]   modulus;

   // Chain plumbing: slot 0 is the generator output, slot CELLS feeds the output stage
   logic [CELLS:0]         chain_valid;
   logic [CELLS:0]         chain_ready;
   pkc_pkg::cell_data_type chain_data [CELLS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_key_ff  <= pkc_pkg::SEED_KEY_RESET;
         max_level_ff <= pkc_pkg::MAX_LEVEL_RESET;
         direction_ff <= pkc_pkg::DIR_ENCODE;
      end else if (csr_wr_en) begin
         case (csr_index)
            pkc_pkg::REG_SEED_KEY: begin
               seed_key_ff <= csr_wdata[pkc_pkg::KEY_BITS-1:0];
            end
            pkc_pkg::REG_MAX_LEVEL: begin
               max_level_ff <= csr_wdata[pkc_pkg::LEVEL_BITS-1:0];
            end
            pkc_pkg::REG_DIRECTION: begin
               direction_ff <= csr_wdata[0];
            end
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // m = max_level + 1, range 1..256
   assign modulus = pkc_pkg::MOD_BITS'(max_level_ff) + pkc_pkg::MOD_BITS'(1);

   // Generator: reload on first pixel, then one Lehmer step per pixel
   pkc_lehmer u_lehmer (
      .clock    (clock),
      .reset    (reset),
      .seed_key (seed_key_ff),
      .up_valid (req_chan.valid),
      .up_ready (req_chan.ready),
      .up_pixel (req_chan.pixel_in),
      .up_first (req_chan.first_pixel),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_data  (chain_data[0])
   );

   // Remainder chain: lane a reduces the generator value (keystream), lane b
   // reduces the pixel; lane b only runs in the last PIXEL_BITS cells.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      pkc_mod_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .lane_b_en (i >= (CELLS - pkc_pkg::PIXEL_BITS)),
         .modulus   (modulus),
         .up_valid  (chain_valid[i]),
         .up_ready  (chain_ready[i]),
         .up_data   (chain_data[i]),
         .dn_valid  (chain_valid[i+1]),
         .dn_ready  (chain_ready[i+1]),
         .dn_data   (chain_data[i+1])
      );
   end

   // Final add/subtract mod m and the result register
   pkc_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .modulus   (modulus),
      .direction (direction_ff),
      .up_valid  (chain_valid[CELLS]),
      .up_ready  (chain_ready[CELLS]),
      .up_data   (chain_data[CELLS]),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_pixel (rsp_chan.pixel_out)
   );

endmodule

`default_nettype wire

>>> sv/pkc_lehmer.sv
// Generator stage: holds the Lehmer state and steps it once per accepted pixel.
`default_nettype none

module pkc_lehmer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [pkc_pkg::KEY_BITS-1:0]   seed_key,
   input  wire logic                           up_valid,
   output logic                                up_ready,
   input  wire logic [pkc_pkg::PIXEL_BITS-1:0] up_pixel,
   input  wire logic                           up_first,
   output logic                                dn_valid,
   input  wire logic                           dn_ready,
   output pkc_pkg::cell_data_type              dn_data
);

   logic                           gen_ff;
   logic [pkc_pkg::KEY_BITS-1:0]   gen_value_ff;
   logic [pkc_pkg::KEY_BITS-1:0]   gen_value_in;
   logic [pkc_pkg::KEY_BITS-1:0]   gen_base;
   logic                           vld_ff;
   logic [pkc_pkg::PIXEL_BITS-1:0] pix_ff;
   logic                           accept;

   assign up_ready = !vld_ff || dn_ready;
   assign accept   = up_valid && up_ready;

   assign gen_base     = up_first ? seed_key : gen_value_ff;
   assign gen_value_in = pkc_pkg::lehmer_next(gen_base);

   // gen_ff marks the slot holding a fresh value (stays in step with vld_ff)
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 1'b0;
         gen_ff       <= 1'b0;
         gen_value_ff <= '0;
      end else begin
         if (up_ready) begin
            vld_ff <= up_valid;
            gen_ff <= up_valid;
         end
         if (accept) begin
            gen_value_ff <= gen_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= up_pixel;
      end
   end

   assign dn_valid      = vld_ff && gen_ff;
   assign dn_data.rem_a = '0;
   assign dn_data.rem_b = '0;
   assign dn_data.div_a = gen_value_ff;
   assign dn_data.div_b = pix_ff;

endmodule

`default_nettype wire

>>> sv/pkc_mod_cell.sv
// Divider chain cell: one restoring remainder step on lane a, and on lane b when enabled, then hand-off.
`default_nettype none

module pkc_mod_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         lane_b_en,
   input  wire logic [pkc_pkg::MOD_BITS-1:0] modulus,
   input  wire logic                         up_valid,
   output logic                              up_ready,
   input  wire pkc_pkg::cell_data_type       up_data,
   output logic                              dn_valid,
   input  wire logic                         dn_ready,
   output pkc_pkg::cell_data_type            dn_data
);

   logic                   vld_ff;
   pkc_pkg::cell_data_type data_ff;
   pkc_pkg::cell_data_type data_in;

   assign up_ready = !vld_ff || dn_ready;

   always_comb begin
      data_in       = up_data;
      data_in.rem_a = pkc_pkg::mod_step(up_data.rem_a, up_data.div_a[pkc_pkg::DIV_BITS-1],
                                        modulus);
      data_in.div_a = {up_data.div_a[pkc_pkg::DIV_BITS-2:0], 1'b0};
      if (lane_b_en) begin
         data_in.rem_b = pkc_pkg::mod_step(up_data.rem_b,
                                           up_data.div_b[pkc_pkg::PIXEL_BITS-1], modulus);
         data_in.div_b = {up_data.div_b[pkc_pkg::PIXEL_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

>>> sv/pkc_out_stage.sv
// Output stage: combines pixel and keystream residues, holds the result beat.
`default_nettype none

module pkc_out_stage (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [pkc_pkg::MOD_BITS-1:0]   modulus,
   input  wire logic                           direction,
   input  wire logic                           up_valid,
   output logic                                up_ready,
   input  wire pkc_pkg::cell_data_type         up_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [pkc_pkg::PIXEL_BITS-1:0]      rsp_pixel
);

   localparam int SUM_BITS = pkc_pkg::MOD_BITS + 1;

   logic                            vld_ff;
   logic [pkc_pkg::PIXEL_BITS-1:0]  pix_ff;
   logic [pkc_pkg::PIXEL_BITS-1:0]  pix_in;
   logic [SUM_BITS-1:0]             sum;
   logic [SUM_BITS-1:0]             modulus_ext;

   assign up_ready    = !vld_ff || rsp_ready;
   assign modulus_ext = SUM_BITS'(modulus);

   // rem_a is the keystream k, rem_b is the pixel reduced mod m
   always_comb begin
      if (direction == pkc_pkg::DIR_DECODE) begin
         sum = SUM_BITS'(up_data.rem_b) + modulus_ext - SUM_BITS'(up_data.rem_a);
      end else begin
         sum = SUM_BITS'(up_data.rem_b) + SUM_BITS'(up_data.rem_a);
      end
      if (sum >= modulus_ext) begin
         sum = sum - modulus_ext;
      end
      pix_in = pkc_pkg::PIXEL_BITS'(sum[pkc_pkg::LEVEL_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         pix_ff <= pix_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_pixel = pix_ff;

endmodule

`default_nettype wire

>>> tb/pixel_keystream_cipher_unit_tb.sv
// Self-checking bench for the pixel keystream cipher unit: directed and random pixel streams.
`default_nettype none

module pixel_keystream_cipher_unit_tb;
   import pkc_pkg::*;

   // Index past the register list; writes to it must leave every register unchanged.
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;
   localparam logic [KEY_BITS-1:0]       KEY_ALL_ONES = 31'h7FFF_FFFF;
   localparam int                        DRAIN_CYCLES = 40;  // pipe depth plus margin
   localparam int                        HOLD_CYCLES  = 150; // long enough to fill the pipe
   localparam int                        RANDOM_ITEMS = 1200;

   // Expected-pixel tracker: mirrors the CSRs and the Lehmer generator.
   class cipher_scoreboard;
      logic [KEY_BITS-1:0]   key;
      logic [LEVEL_BITS-1:0] top_level;
      logic                  decode;
      logic [KEY_BITS-1:0]   gen_state;
      logic [PIXEL_BITS-1:0] expected_q[$];
      int                    errors;

      function new();
         key       = SEED_KEY_RESET;
         top_level = MAX_LEVEL_RESET;
         decode    = DIR_ENCODE;
         gen_state = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_SEED_KEY:  key       = data[KEY_BITS-1:0];
            REG_MAX_LEVEL: top_level = data[LEVEL_BITS-1:0];
            REG_DIRECTION: decode    = data[0];
            default: ;
         endcase
      endfunction

      // Accepted pixel beat: step the generator and queue the ciphered level.
      function void note_pixel(logic [PIXEL_BITS-1:0] pix, logic first);
         longint unsigned prod;
         int unsigned     modulus;
         int unsigned     stream_val;
         int unsigned     res;
         if (first) gen_state = key;
         prod      = longint'(gen_state) * longint'(LEHMER_MULT);
         gen_state = KEY_BITS'(prod % longint'(LEHMER_MOD));
         modulus    = int'(top_level) + 1;
         stream_val = int'(gen_state) % modulus;
         if (decode == DIR_DECODE) res = (int'(pix) + modulus - stream_val) % modulus;
         else                      res = (int'(pix) + stream_val) % modulus;
         expected_q.push_back(PIXEL_BITS'(res));
      endfunction

      function void check_pixel(logic [PIXEL_BITS-1:0] got);
         logic [PIXEL_BITS-1:0] want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected rsp beat: pixel_out %0d", got));
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) report($sformatf("pixel_out: expected %0d, got %0d", want, got));
      endfunction

      function void report(string what);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   pkc_req_if req_chan ();
   pkc_rsp_if rsp_chan ();

   cipher_scoreboard sb = new();

   bit idle_on          = 1'b1; // random gaps on both channels
   int rsp_hold_request = 0;    // cycles the receiver should hold off, picked up by it
   int pixels_sent      = 0;

   pixel_keystream_cipher_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #(300_000 * 20);
      $display("Mismatches found");
      $finish;
   end

   // Offer one pixel beat, with an optional gap first; valid stays high on return
   // so back-to-back beats never see a low/high pair in one step.
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input logic first);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < 34) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.pixel_in    <= pix;
      req_chan.first_pixel <= first;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_pixel(pix, first);
      pixels_sent++;
   endtask

   // Stop offering and wait for every queued pixel to come back.
   task automatic finish_burst();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0]  data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Drain, then program all three registers in a random rotation of their order.
   task automatic apply_settings(input logic [KEY_BITS-1:0] key, input int unsigned level,
                                 input logic dir);
      int order;
      finish_burst();
      order = $urandom_range(2);
      for (int i = 0; i < 3; i++) begin
         case ((order + i) % 3)
            0: csr_write(REG_SEED_KEY, key);
            1: csr_write(REG_MAX_LEVEL, CSR_DATA_BITS'(level));
            default: csr_write(REG_DIRECTION, {{(CSR_DATA_BITS-1){1'b0}}, dir});
         endcase
      end
   endtask

   // Receiver: checks accepted beats, then picks its ready for the next edge.
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            sb.check_pixel(rsp_chan.pixel_out);
         if (rsp_hold_request > 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(99) < 34) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [KEY_BITS-1:0] key;
      int unsigned         level;
      int unsigned         img_len;
      int                  phase;
      logic [PIXEL_BITS-1:0] pix;

      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.pixel_in    = '0;
      req_chan.first_pixel = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Never keyed since reset: generator sits at zero, pixels pass straight through.
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'hAA, 1'b0);
      send_pixel(8'h55, 1'b0);
      // Reset key of one, full 8-bit range, encode.
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);

      // Key zero collapses the generator to zero; decode.
      apply_settings('0, 255, DIR_DECODE);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd17, 1'b0);

      // All-ones key is the prime itself; modulus of one forces every output to zero.
      apply_settings(KEY_ALL_ONES, 0, DIR_ENCODE);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b0);

      // Level of one, pixels above it, mid-stream rekey.
      apply_settings(31'h0123_4567, 1, DIR_DECODE);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd200, 1'b1);

      // Junk above the field widths is dropped; unmapped index is a no-op.
      finish_burst();
      csr_write(REG_MAX_LEVEL, 31'h7FFF_FF80);
      csr_write(REG_DIRECTION, 31'h7FFF_FFFE);
      csr_write(REG_UNMAPPED, 31'h2AAA_AAAA);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd127, 1'b0);
      send_pixel(8'd128, 1'b0);

      // Random part: one setting per phase, images are a keyed beat plus raster pixels.
      phase = 0;
      while (pixels_sent < RANDOM_ITEMS) begin
         case ($urandom_range(5))
            0:       key = '0;
            1:       key = KEY_ALL_ONES;
            2:       key = 31'd1;
            default: key = KEY_BITS'($urandom());
         endcase
         case ($urandom_range(5))
            0:       level = 0;
            1:       level = 1;
            2:       level = 255;
            default: level = $urandom_range(2, 254);
         endcase
         apply_settings(key, level, logic'($urandom_range(1)));
         if ($urandom_range(3) == 0) csr_write(REG_UNMAPPED, CSR_DATA_BITS'($urandom()));

         idle_on = (phase != 3); // one long stretch at full rate
         if (phase == 5) rsp_hold_request = HOLD_CYCLES;

         for (int img = 0; img < 4; img++) begin
            if (phase == 7 && img == 2) finish_burst(); // sender pause mid-phase
            // long images while the receiver holds off, so the chain surely fills
            img_len = (phase == 5) ? 30 : $urandom_range(4, 30);
            for (int n = 0; n < img_len; n++) begin
               case ($urandom_range(9))
                  0:       pix = 8'd0;
                  1:       pix = 8'd255;
                  2, 3:    pix = PIXEL_BITS'($urandom_range(sb.top_level));
                  default: pix = PIXEL_BITS'($urandom());
               endcase
               // Mostly clean images; now and then a stray rekey mid-image.
               send_pixel(pix, (n == 0) || ($urandom_range(19) == 0));
            end
         end
         phase++;
      end

      idle_on = 1'b1;
      finish_burst();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() > 0) sb.report($sformatf("%0d pixels never came out", sb.pending()));

      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
